@@ hdl/lsps_pkg.sv @@
// Shared types and constants for the LED strip pixel serializer.
// Used by lsps_front, lsps_back and the top level; no dependencies.
package lsps_pkg;

  // Pixel store depth and pixel format
  parameter logic [6:0] MAX_LEDS   = 7'd64;
  parameter logic [4:0] PIXEL_BITS = 5'd24;

  // Input action codes
  parameter logic [2:0] ACT_WRITE = 3'd0;
  parameter logic [2:0] ACT_ADD   = 3'd1;
  parameter logic [2:0] ACT_SUB   = 3'd2;
  parameter logic [2:0] ACT_START = 3'd3;
  parameter logic [2:0] ACT_TICK  = 3'd4;

  // Channel select codes
  parameter logic [1:0] CH_RED   = 2'd0;
  parameter logic [1:0] CH_GREEN = 2'd1;
  parameter logic [1:0] CH_BLUE  = 2'd2;

  // Configuration register indexes
  parameter logic [2:0] CFG_LED_COUNT  = 3'd0;
  parameter logic [2:0] CFG_BIT_PERIOD = 3'd1;
  parameter logic [2:0] CFG_ONE_HIGH   = 3'd2;
  parameter logic [2:0] CFG_ZERO_HIGH  = 3'd3;
  parameter logic [2:0] CFG_LATCH_LOW  = 3'd4;

  // Configuration reset values
  parameter logic [6:0]  RST_LED_COUNT  = 7'd8;
  parameter logic [15:0] RST_BIT_PERIOD = 16'd90;
  parameter logic [15:0] RST_ONE_HIGH   = 16'd57;
  parameter logic [15:0] RST_ZERO_HIGH  = 16'd28;
  parameter logic [15:0] RST_LATCH_LOW  = 16'd1200;

  // Classified command, as it travels through the queue
  typedef enum logic [2:0] {
    CMD_WRITE,
    CMD_ADD,
    CMD_SUB,
    CMD_START,
    CMD_TICK,
    CMD_BAD
  } cmd_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [5:0] led_index;
    logic [7:0] red_value;
    logic [7:0] green_value;
    logic [7:0] blue_value;
    logic [1:0] channel;
    logic [7:0] step_amount;
  } item_t;

  typedef struct packed {
    logic [6:0]  led_count;
    logic [15:0] bit_period_ticks;
    logic [15:0] one_high_ticks;
    logic [15:0] zero_high_ticks;
    logic [15:0] latch_low_ticks;
  } cfg_t;

endpackage

@@ hdl/lsps_front.sv @@
// Front end: accepts input items, classifies the action, queues them.
// Two-entry queue toward lsps_back. Depends on lsps_pkg.
module lsps_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        in_action,
  input  logic [5:0]        in_led_index,
  input  logic [7:0]        in_red_value,
  input  logic [7:0]        in_green_value,
  input  logic [7:0]        in_blue_value,
  input  logic [1:0]        in_channel,
  input  logic [7:0]        in_step_amount,
  output logic              q_valid,
  output lsps_pkg::item_t   q_item,
  input  logic              q_pop
);

  lsps_pkg::item_t q_mem [2];
  lsps_pkg::item_t item_in;
  logic            wr_ptr_r, wr_ptr_nxt;
  logic            rd_ptr_r, rd_ptr_nxt;
  logic [1:0]      cnt_r, cnt_nxt;
  logic            push;
  logic            pop;

  // Classify: unknown actions and a bad channel never touch state
  always_comb begin
    item_in.led_index   = in_led_index;
    item_in.red_value   = in_red_value;
    item_in.green_value = in_green_value;
    item_in.blue_value  = in_blue_value;
    item_in.channel     = in_channel;
    item_in.step_amount = in_step_amount;
    case (in_action)
      lsps_pkg::ACT_WRITE: item_in.cmd = lsps_pkg::CMD_WRITE;
      lsps_pkg::ACT_ADD:   item_in.cmd = (in_channel > lsps_pkg::CH_BLUE) ?
                                         lsps_pkg::CMD_BAD : lsps_pkg::CMD_ADD;
      lsps_pkg::ACT_SUB:   item_in.cmd = (in_channel > lsps_pkg::CH_BLUE) ?
                                         lsps_pkg::CMD_BAD : lsps_pkg::CMD_SUB;
      lsps_pkg::ACT_START: item_in.cmd = lsps_pkg::CMD_START;
      lsps_pkg::ACT_TICK:  item_in.cmd = lsps_pkg::CMD_TICK;
      default:             item_in.cmd = lsps_pkg::CMD_BAD;
    endcase
  end

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_pop && q_valid;
  assign q_item   = q_mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= item_in;
    end
  end

endmodule

@@ hdl/lsps_back.sv @@
// Back end: pixel store, waveform sequencer and result register.
// Takes classified items from lsps_front. Depends on lsps_pkg.
module lsps_back (
  input  logic            clk,
  input  logic            rst_n,
  input  lsps_pkg::cfg_t  cfg,
  input  logic            q_valid,
  input  lsps_pkg::item_t q_item,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic            out_line_level,
  output logic            out_busy_res,
  output logic            out_rejected
);

  typedef enum logic {
    ST_EXEC,
    ST_READ
  } state_t;

  state_t      state_r, state_nxt;
  logic        sending_r, sending_nxt;
  logic        latching_r, latching_nxt;
  logic [6:0]  pc_r, pc_nxt;
  logic [4:0]  bc_r, bc_nxt;
  logic [23:0] shift_r, shift_nxt;
  logic [15:0] tc_r, tc_nxt;
  logic        out_valid_r;
  logic        out_level_r;
  logic        out_busy_r;
  logic        out_rej_r;

  // Pixel store: {red, green, blue}; entries read as zero until written
  logic [23:0] mem [64];
  logic [63:0] vld_r;
  logic [23:0] rd_data_r;
  logic        rd_vld_r;
  logic [23:0] pix;

  logic        busy;
  logic [6:0]  eff_cnt;
  logic [15:0] eff_per;
  logic [15:0] lim;
  logic [15:0] hsel;
  logic [15:0] cur_high;
  logic        held;
  logic [16:0] tc_inc;
  logic [4:0]  bc_inc;
  logic [6:0]  pc_inc;
  logic [7:0]  chan_val;
  logic [7:0]  chan_new;
  logic        need_rd;
  logic [5:0]  rd_addr;
  logic        rd_en;
  logic        wr_en;
  logic [23:0] wr_data;
  logic        level;
  logic        rej;
  logic        slot_free;
  logic        commit;

  assign pix       = rd_vld_r ? rd_data_r : 24'd0;
  assign busy      = sending_r || latching_r;
  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    eff_cnt  = (cfg.led_count > lsps_pkg::MAX_LEDS) ? lsps_pkg::MAX_LEDS : cfg.led_count;
    eff_per  = (cfg.bit_period_ticks < 16'd2) ? 16'd2 : cfg.bit_period_ticks;
    lim      = eff_per - 16'd1;
    hsel     = shift_r[23] ? cfg.one_high_ticks : cfg.zero_high_ticks;
    cur_high = (hsel > lim) ? lim : hsel;
    held     = sending_r && (tc_r != 16'd0) && ((tc_r - 16'd1) < cur_high);
    tc_inc   = {1'b0, tc_r} + 17'd1;
    bc_inc   = bc_r + 5'd1;
    pc_inc   = pc_r + 7'd1;
  end

  // Per-item execution; sequencer and store state only move on commit
  always_comb begin
    sending_nxt  = sending_r;
    latching_nxt = latching_r;
    pc_nxt       = pc_r;
    bc_nxt       = bc_r;
    shift_nxt    = shift_r;
    tc_nxt       = tc_r;
    level        = held;
    rej          = 1'b0;
    need_rd      = 1'b0;
    rd_addr      = q_item.led_index;
    wr_en        = 1'b0;
    wr_data      = 24'd0;
    chan_val     = 8'd0;
    chan_new     = 8'd0;

    if (q_item.cmd == lsps_pkg::CMD_TICK) begin
      if (sending_r) begin
        level = (tc_r < cur_high);
        if (tc_inc >= {1'b0, eff_per}) begin
          tc_nxt    = 16'd0;
          shift_nxt = {shift_r[22:0], 1'b0};
          if (bc_inc >= lsps_pkg::PIXEL_BITS) begin
            bc_nxt = 5'd0;
            pc_nxt = pc_inc;
            if (pc_inc >= eff_cnt) begin
              sending_nxt  = 1'b0;
              latching_nxt = 1'b1;
            end else begin
              // next pixel goes out green, red, blue
              need_rd   = 1'b1;
              rd_addr   = pc_inc[5:0];
              shift_nxt = {pix[15:8], pix[23:16], pix[7:0]};
            end
          end else begin
            bc_nxt = bc_inc;
          end
        end else begin
          tc_nxt = tc_inc[15:0];
        end
      end else if (latching_r) begin
        if (tc_inc >= {1'b0, cfg.latch_low_ticks}) begin
          latching_nxt = 1'b0;
          tc_nxt       = 16'd0;
        end else begin
          tc_nxt = tc_inc[15:0];
        end
      end
    end else if (busy || q_item.cmd == lsps_pkg::CMD_BAD) begin
      rej = 1'b1;
    end else if (q_item.cmd == lsps_pkg::CMD_START) begin
      pc_nxt = 7'd0;
      bc_nxt = 5'd0;
      tc_nxt = 16'd0;
      if (eff_cnt == 7'd0) begin
        shift_nxt    = 24'd0;
        latching_nxt = 1'b1;
      end else begin
        need_rd     = 1'b1;
        rd_addr     = 6'd0;
        shift_nxt   = {pix[15:8], pix[23:16], pix[7:0]};
        sending_nxt = 1'b1;
      end
    end else if ({1'b0, q_item.led_index} >= eff_cnt) begin
      rej = 1'b1;
    end else if (q_item.cmd == lsps_pkg::CMD_WRITE) begin
      wr_en   = 1'b1;
      wr_data = {q_item.red_value, q_item.green_value, q_item.blue_value};
    end else begin
      // add or subtract, read-modify-write of one channel
      need_rd = 1'b1;
      wr_en   = 1'b1;
      case (q_item.channel)
        lsps_pkg::CH_RED:   chan_val = pix[23:16];
        lsps_pkg::CH_GREEN: chan_val = pix[15:8];
        default:            chan_val = pix[7:0];
      endcase
      chan_new = (q_item.cmd == lsps_pkg::CMD_ADD) ? (chan_val + q_item.step_amount) :
                                                     (chan_val - q_item.step_amount);
      case (q_item.channel)
        lsps_pkg::CH_RED:   wr_data = {chan_new, pix[15:0]};
        lsps_pkg::CH_GREEN: wr_data = {pix[23:16], chan_new, pix[7:0]};
        default:            wr_data = {pix[23:8], chan_new};
      endcase
    end
  end

  always_comb begin
    commit    = q_valid && slot_free && (!need_rd || state_r == ST_READ);
    rd_en     = q_valid && need_rd && (state_r == ST_EXEC);
    state_nxt = state_r;
    if (rd_en) begin
      state_nxt = ST_READ;
    end else if (commit) begin
      state_nxt = ST_EXEC;
    end
  end

  assign q_pop = commit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_EXEC;
      sending_r   <= 1'b0;
      latching_r  <= 1'b0;
      pc_r        <= 7'd0;
      bc_r        <= 5'd0;
      shift_r     <= 24'd0;
      tc_r        <= 16'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (commit) begin
        sending_r   <= sending_nxt;
        latching_r  <= latching_nxt;
        pc_r        <= pc_nxt;
        bc_r        <= bc_nxt;
        shift_r     <= shift_nxt;
        tc_r        <= tc_nxt;
        out_valid_r <= 1'b1;
        out_level_r <= level;
        out_busy_r  <= sending_nxt || latching_nxt;
        out_rej_r   <= rej;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 64'd0;
    end else if (commit && wr_en) begin
      vld_r[q_item.led_index] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (commit && wr_en) begin
      mem[q_item.led_index] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
      rd_vld_r  <= vld_r[rd_addr];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_line_level = out_level_r;
  assign out_busy_res   = out_busy_r;
  assign out_rejected   = out_rej_r;

endmodule

@@ hdl/led_strip_pixel_serializer_core.sv @@
// LED strip pixel serializer, top level: config registers, front queue, back end.
// Path: front queue, registered result; store reads first pass the read state.
// Throughput: 1 item/cycle unless out_stall holds it; add, subtract, start and a tick
//   loading the next pixel first pass a registered single-port pixel store read.
// Reset (rst_n, sync, active low): config to 8/90/57/28/1200, store reads as zero,
//   queue empty, line idle. Depends on lsps_pkg, lsps_front, lsps_back.
module led_strip_pixel_serializer_core (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // input item channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_action,
  input  logic [5:0]  in_led_index,
  input  logic [7:0]  in_red_value,
  input  logic [7:0]  in_green_value,
  input  logic [7:0]  in_blue_value,
  input  logic [1:0]  in_channel,
  input  logic [7:0]  in_step_amount,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_line_level,
  output logic        out_busy_res,
  output logic        out_rejected
);

  lsps_pkg::cfg_t  cfg_r, cfg_nxt;
  lsps_pkg::item_t q_item;
  logic            q_valid;
  logic            q_pop;

  // Config is always writable; indexes past the list are dropped
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lsps_pkg::CFG_LED_COUNT:  cfg_nxt.led_count        = cfg_data[6:0];
        lsps_pkg::CFG_BIT_PERIOD: cfg_nxt.bit_period_ticks = cfg_data;
        lsps_pkg::CFG_ONE_HIGH:   cfg_nxt.one_high_ticks   = cfg_data;
        lsps_pkg::CFG_ZERO_HIGH:  cfg_nxt.zero_high_ticks  = cfg_data;
        lsps_pkg::CFG_LATCH_LOW:  cfg_nxt.latch_low_ticks  = cfg_data;
        default:                  cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.led_count        <= lsps_pkg::RST_LED_COUNT;
      cfg_r.bit_period_ticks <= lsps_pkg::RST_BIT_PERIOD;
      cfg_r.one_high_ticks   <= lsps_pkg::RST_ONE_HIGH;
      cfg_r.zero_high_ticks  <= lsps_pkg::RST_ZERO_HIGH;
      cfg_r.latch_low_ticks  <= lsps_pkg::RST_LATCH_LOW;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front: decode and queue, stalls only when the queue is full
  lsps_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_led_index   (in_led_index),
    .in_red_value   (in_red_value),
    .in_green_value (in_green_value),
    .in_blue_value  (in_blue_value),
    .in_channel     (in_channel),
    .in_step_amount (in_step_amount),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop)
  );

  // Back: pixel store, bit/pixel/latch sequencing, registered result
  lsps_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_line_level (out_line_level),
    .out_busy_res   (out_busy_res),
    .out_rejected   (out_rejected)
  );

endmodule

@@ verif/tb_top.sv @@
// Self-checking bench for led_strip_pixel_serializer_core: pixel store traffic,
// refresh serialization and latch timing, checked against an in-bench predictor.
// Depends on lsps_pkg and the RTL under hdl/.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Codes the package leaves out: the unused channel select and a spare reg index
  localparam logic [1:0] CH_NONE   = 2'd3;
  localparam logic [2:0] CFG_SPARE = 3'd7;

  localparam int RANDOM_ITEMS = 500;
  localparam int QUIET_LIMIT  = 2000;  // cycles with no transfer on any channel
  localparam int MAX_GAP      = 18;

  typedef struct packed {
    logic [2:0] action;
    logic [5:0] led_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [1:0] channel;
    logic [7:0] step;
  } strip_item_t;

  typedef struct packed {
    logic line_level;
    logic busy;
    logic rejected;
  } strip_state_t;

  // ---------------------------------------------------------------------------
  // DUT and its inputs, all known from time zero
  // ---------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_action = '0;
  logic [5:0]  in_led_index = '0;
  logic [7:0]  in_red_value = '0;
  logic [7:0]  in_green_value = '0;
  logic [7:0]  in_blue_value = '0;
  logic [1:0]  in_channel = '0;
  logic [7:0]  in_step_amount = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_line_level;
  logic        out_busy_res;
  logic        out_rejected;

  led_strip_pixel_serializer_core uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_led_index   (in_led_index),
    .in_red_value   (in_red_value),
    .in_green_value (in_green_value),
    .in_blue_value  (in_blue_value),
    .in_channel     (in_channel),
    .in_step_amount (in_step_amount),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_line_level (out_line_level),
    .out_busy_res   (out_busy_res),
    .out_rejected   (out_rejected)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor state: shadow registers, pixel store and serializer
  // ---------------------------------------------------------------------------
  lsps_pkg::cfg_t strip_cfg;
  logic [23:0] pixel_mem [0:63];   // {red, green, blue}
  logic        line_sending;
  logic        line_latching;
  logic [6:0]  pix_ctr;
  logic [4:0]  bit_ctr;
  logic [23:0] shift_word;         // {green, red, blue}, MSB goes out first
  logic [15:0] tick_ctr;

  strip_item_t  pending_items [$];    // items waiting for the driver
  strip_state_t expected_states [$];  // predicted results, oldest first

  // Handshake flags, sampled at the rising edge
  bit in_sent, out_sent, cfg_sent;
  int quiet_cycles = 0;
  int fault_count = 0;

  // Pacing
  bit src_calm = 1'b1;
  bit snk_calm = 1'b1;
  int src_wait = 0;
  int sink_wait = 0;
  strip_item_t next_item;
  strip_item_t seen_item;
  strip_state_t want;

  function automatic logic [6:0] live_count();
    return (strip_cfg.led_count > lsps_pkg::MAX_LEDS) ? lsps_pkg::MAX_LEDS :
                                                        strip_cfg.led_count;
  endfunction

  function automatic logic [15:0] live_period();
    return (strip_cfg.bit_period_ticks < 16'd2) ? 16'd2 : strip_cfg.bit_period_ticks;
  endfunction

  // High time of the bit now at the head of the shift word, capped below the period
  function automatic logic [15:0] high_ticks();
    logic [15:0] h;
    logic [15:0] lim;
    h = shift_word[23] ? strip_cfg.one_high_ticks : strip_cfg.zero_high_ticks;
    lim = live_period() - 16'd1;
    return (h > lim) ? lim : h;
  endfunction

  // Reorder store layout into wire order: green, red, blue
  function automatic void load_shift(logic [6:0] idx);
    logic [23:0] p;
    p = pixel_mem[idx[5:0]];
    shift_word = {p[15:8], p[23:16], p[7:0]};
  endfunction

  // Level left on the line by the most recent tick
  function automatic logic held_line();
    if (!line_sending || tick_ctr == 16'd0) return 1'b0;
    return (tick_ctr - 16'd1) < high_ticks();
  endfunction

  function automatic logic tick_line();
    logic lvl;
    lvl = 1'b0;
    if (line_sending) begin
      lvl = tick_ctr < high_ticks();
      tick_ctr = tick_ctr + 16'd1;
      if (tick_ctr >= live_period()) begin
        tick_ctr = '0;
        shift_word = shift_word << 1;
        bit_ctr = bit_ctr + 5'd1;
        if (bit_ctr >= lsps_pkg::PIXEL_BITS) begin
          bit_ctr = '0;
          pix_ctr = pix_ctr + 7'd1;
          if (pix_ctr >= live_count()) begin
            line_sending = 1'b0;
            line_latching = 1'b1;
          end else begin
            load_shift(pix_ctr);
          end
        end
      end
    end else if (line_latching) begin
      // latch time of zero still takes one tick: the compare follows the increment
      tick_ctr = tick_ctr + 16'd1;
      if (tick_ctr >= strip_cfg.latch_low_ticks) begin
        line_latching = 1'b0;
        tick_ctr = '0;
      end
    end
    return lvl;
  endfunction

  function automatic strip_state_t advance_strip(strip_item_t it);
    strip_state_t r;
    logic [23:0]  p;
    logic [7:0]   v;
    r = '0;
    if (it.action == lsps_pkg::ACT_TICK) begin
      r.line_level = tick_line();
    end else begin
      r.line_level = held_line();
      if (line_sending || line_latching || it.action > lsps_pkg::ACT_TICK) begin
        r.rejected = 1'b1;
      end else if (it.action == lsps_pkg::ACT_START) begin
        pix_ctr = '0;
        bit_ctr = '0;
        tick_ctr = '0;
        if (live_count() == 7'd0) begin
          // empty strip: straight to the latch gap
          shift_word = '0;
          line_latching = 1'b1;
        end else begin
          load_shift(7'd0);
          line_sending = 1'b1;
        end
      end else if ({1'b0, it.led_index} >= live_count()) begin
        r.rejected = 1'b1;
      end else if (it.action == lsps_pkg::ACT_WRITE) begin
        pixel_mem[it.led_index] = {it.red, it.green, it.blue};
      end else if (it.channel == CH_NONE) begin
        r.rejected = 1'b1;
      end else begin
        p = pixel_mem[it.led_index];
        case (it.channel)
          lsps_pkg::CH_RED:   v = p[23:16];
          lsps_pkg::CH_GREEN: v = p[15:8];
          default:            v = p[7:0];
        endcase
        v = (it.action == lsps_pkg::ACT_ADD) ? v + it.step : v - it.step;  // wraps mod 256
        case (it.channel)
          lsps_pkg::CH_RED:   p[23:16] = v;
          lsps_pkg::CH_GREEN: p[15:8] = v;
          default:            p[7:0] = v;
        endcase
        pixel_mem[it.led_index] = p;
      end
    end
    r.busy = line_sending | line_latching;
    return r;
  endfunction

  function automatic void shadow_register(logic [2:0] idx, logic [15:0] val);
    case (idx)
      lsps_pkg::CFG_LED_COUNT:  strip_cfg.led_count = val[6:0];
      lsps_pkg::CFG_BIT_PERIOD: strip_cfg.bit_period_ticks = val;
      lsps_pkg::CFG_ONE_HIGH:   strip_cfg.one_high_ticks = val;
      lsps_pkg::CFG_ZERO_HIGH:  strip_cfg.zero_high_ticks = val;
      lsps_pkg::CFG_LATCH_LOW:  strip_cfg.latch_low_ticks = val;
      default: ;  // spare indexes are dropped
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Rising edge: record transfers, run the predictor, check results
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    in_sent = rst_n && in_valid && (in_stall === 1'b0);
    out_sent = rst_n && (out_valid === 1'b1) && !out_stall;
    cfg_sent = rst_n && cfg_valid && (cfg_ready === 1'b1);
    quiet_cycles = (in_sent || out_sent || cfg_sent) ? 0 : quiet_cycles + 1;

    if (cfg_sent) shadow_register(cfg_index, cfg_data);

    if (in_sent) begin
      seen_item = '{action: in_action, led_index: in_led_index, red: in_red_value,
                    green: in_green_value, blue: in_blue_value, channel: in_channel,
                    step: in_step_amount};
      expected_states.push_back(advance_strip(seen_item));
    end

    if (out_sent) begin
      if (expected_states.size() == 0) begin
        $error("result transfer with nothing expected");
        fault_count++;
      end else begin
        want = expected_states.pop_front();
        if (out_line_level !== want.line_level) begin
          $error("line_level: expected %0b, got %0b", want.line_level, out_line_level);
          fault_count++;
        end
        if (out_busy_res !== want.busy) begin
          $error("busy_res: expected %0b, got %0b", want.busy, out_busy_res);
          fault_count++;
        end
        if (out_rejected !== want.rejected) begin
          $error("rejected: expected %0b, got %0b", want.rejected, out_rejected);
          fault_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Falling edge: item driver. Holds a stalled item, then waits its drawn gap.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : item_driver
    if (in_valid && !in_sent) begin
      // stalled: payload stays put
    end else if (src_wait > 0) begin
      in_valid <= 1'b0;
      src_wait <= src_wait - 1;
    end else if (pending_items.size() != 0) begin
      next_item = pending_items.pop_front();
      in_action      <= next_item.action;
      in_led_index   <= next_item.led_index;
      in_red_value   <= next_item.red;
      in_green_value <= next_item.green;
      in_blue_value  <= next_item.blue;
      in_channel     <= next_item.channel;
      in_step_amount <= next_item.step;
      in_valid       <= 1'b1;
      src_wait       <= src_calm ? 0 : $urandom_range(0, MAX_GAP);
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Falling edge: result-side stall, a fresh stretch drawn after every transfer
  always @(negedge clk) begin : sink_pacing
    if (out_sent) sink_wait = snk_calm ? 0 : $urandom_range(0, MAX_GAP);
    if (sink_wait > 0) begin
      out_stall <= 1'b1;
      sink_wait = sink_wait - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin : watchdog
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("tb_top: FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic strip_item_t rand_item(logic [2:0] act);
    strip_item_t it;
    it.action    = act;
    it.led_index = 6'($urandom_range(0, 63));
    it.red       = 8'($urandom_range(0, 255));
    it.green     = 8'($urandom_range(0, 255));
    it.blue      = 8'($urandom_range(0, 255));
    it.channel   = 2'($urandom_range(0, 3));
    it.step      = 8'($urandom_range(0, 255));
    return it;
  endfunction

  task automatic queue_plain(logic [2:0] act);
    pending_items.push_back(rand_item(act));
  endtask

  task automatic queue_pixel(logic [5:0] idx, logic [7:0] r, logic [7:0] g,
                             logic [7:0] b);
    strip_item_t it;
    it = rand_item(lsps_pkg::ACT_WRITE);
    it.led_index = idx;
    it.red = r;
    it.green = g;
    it.blue = b;
    pending_items.push_back(it);
  endtask

  task automatic queue_adjust(logic [2:0] act, logic [5:0] idx, logic [1:0] ch,
                              logic [7:0] amt);
    strip_item_t it;
    it = rand_item(act);
    it.led_index = idx;
    it.channel = ch;
    it.step = amt;
    pending_items.push_back(it);
  endtask

  // Register write over the config channel; only called with nothing in flight
  task automatic set_register(logic [2:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Sender holds off until every queued item is taken and every result is back
  task automatic wait_drain();
    do @(posedge clk);
    while (pending_items.size() != 0 || in_valid || expected_states.size() != 0);
  endtask

  // Tick until the predictor says the refresh and latch gap are over
  task automatic run_out_refresh();
    while (line_sending || line_latching) begin
      repeat (24) queue_plain(lsps_pkg::ACT_TICK);
      wait_drain();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [2:0] code;
    int normal_items;
    int cnt, per, n_ticks;

    strip_cfg = '{led_count: lsps_pkg::RST_LED_COUNT,
                  bit_period_ticks: lsps_pkg::RST_BIT_PERIOD,
                  one_high_ticks: lsps_pkg::RST_ONE_HIGH,
                  zero_high_ticks: lsps_pkg::RST_ZERO_HIGH,
                  latch_low_ticks: lsps_pkg::RST_LATCH_LOW};
    for (int i = 0; i < 64; i++) pixel_mem[i] = '0;
    line_sending = 1'b0;
    line_latching = 1'b0;
    pix_ctr = '0;
    bit_ctr = '0;
    shift_word = '0;
    tick_ctr = '0;
    normal_items = 0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset config (8 pixels): idle tick, store edges, wrapping math, bad codes
    queue_plain(lsps_pkg::ACT_TICK);                    // idle: line stays low
    queue_pixel(6'd7, 8'hFF, 8'h00, 8'h80);
    queue_pixel(6'd8, 8'h12, 8'h34, 8'h56);             // index == count
    queue_pixel(6'd63, 8'hFF, 8'hFF, 8'hFF);            // far out of range
    queue_adjust(lsps_pkg::ACT_ADD, 6'd7, lsps_pkg::CH_RED, 8'hFF);    // ff + ff wraps
    queue_adjust(lsps_pkg::ACT_SUB, 6'd0, lsps_pkg::CH_BLUE, 8'h01);   // 0 - 1 wraps
    queue_adjust(lsps_pkg::ACT_ADD, 6'd0, lsps_pkg::CH_GREEN, 8'h00);
    queue_adjust(lsps_pkg::ACT_ADD, 6'd0, CH_NONE, 8'h05);             // no such channel
    code = lsps_pkg::ACT_TICK;
    repeat (3) begin                                    // undefined actions
      code = code + 3'd1;
      queue_plain(code);
    end
    wait_drain();

    // Empty strip: count field masks to 0, start goes straight to the latch gap;
    // period below 2 and zero latch time clamp
    set_register(CFG_SPARE, 16'hFFFF);
    set_register(lsps_pkg::CFG_LED_COUNT, 16'h0080);
    set_register(lsps_pkg::CFG_BIT_PERIOD, 16'd1);
    set_register(lsps_pkg::CFG_LATCH_LOW, 16'd0);
    queue_pixel(6'd0, 8'h01, 8'h02, 8'h03);             // every index rejected
    queue_plain(lsps_pkg::ACT_START);
    queue_pixel(6'd0, 8'h01, 8'h02, 8'h03);             // busy
    queue_plain(lsps_pkg::ACT_TICK);                    // one-tick latch
    queue_plain(lsps_pkg::ACT_TICK);
    wait_drain();

    // Count above the store depth acts as the full store
    set_register(lsps_pkg::CFG_LED_COUNT, 16'd127);
    queue_pixel(6'd63, 8'h00, 8'hFF, 8'h01);
    queue_adjust(lsps_pkg::ACT_SUB, 6'd63, lsps_pkg::CH_GREEN, 8'h81);
    queue_pixel(6'd0, 8'h55, 8'hFF, 8'h00);             // leading one bit
    wait_drain();

    // Longest timings; one-high saturates at period - 1, zero-high of 0
    set_register(lsps_pkg::CFG_LED_COUNT, 16'd1);
    set_register(lsps_pkg::CFG_BIT_PERIOD, 16'hFFFF);
    set_register(lsps_pkg::CFG_ONE_HIGH, 16'hFFFF);
    set_register(lsps_pkg::CFG_ZERO_HIGH, 16'd0);
    set_register(lsps_pkg::CFG_LATCH_LOW, 16'hFFFF);
    queue_plain(lsps_pkg::ACT_START);
    queue_plain(lsps_pkg::ACT_TICK);
    queue_plain(lsps_pkg::ACT_TICK);
    queue_plain(lsps_pkg::ACT_START);                   // busy
    queue_adjust(lsps_pkg::ACT_ADD, 6'd0, lsps_pkg::CH_RED, 8'h10);    // busy
    wait_drain();

    // Mid-refresh rewrite: the short timings apply to the bit in progress
    set_register(lsps_pkg::CFG_BIT_PERIOD, 16'd2);
    set_register(lsps_pkg::CFG_LATCH_LOW, 16'd3);
    run_out_refresh();

    // Random part: mostly full refresh sequences on short strips, with noise
    while (normal_items < RANDOM_ITEMS) begin
      src_calm = ($urandom_range(0, 2) == 0);
      snk_calm = ($urandom_range(0, 2) == 0);
      if ($urandom_range(0, 5) == 0) begin
        // large count: store traffic over the whole index range, no refresh
        set_register(lsps_pkg::CFG_LED_COUNT, 16'($urandom_range(64, 127)));
        repeat ($urandom_range(8, 30)) begin
          pending_items.push_back(
            rand_item(3'($urandom_range(lsps_pkg::ACT_WRITE, lsps_pkg::ACT_SUB))));
          normal_items++;
        end
      end else begin
        cnt = $urandom_range(1, 2);
        per = $urandom_range(0, 3);
        set_register(lsps_pkg::CFG_LED_COUNT, 16'(cnt));
        set_register(lsps_pkg::CFG_BIT_PERIOD, 16'(per));
        set_register(lsps_pkg::CFG_ONE_HIGH, 16'($urandom_range(0, 4)));
        set_register(lsps_pkg::CFG_ZERO_HIGH, 16'($urandom_range(0, 4)));
        set_register(lsps_pkg::CFG_LATCH_LOW, 16'($urandom_range(0, 5)));
        if (per < 2) per = 2;
        repeat ($urandom_range(2, 6)) begin
          queue_pixel(6'($urandom_range(0, cnt)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
          normal_items++;
        end
        repeat ($urandom_range(0, 4)) begin
          queue_adjust(3'($urandom_range(lsps_pkg::ACT_ADD, lsps_pkg::ACT_SUB)),
                       6'($urandom_range(0, cnt)), 2'($urandom_range(0, 3)),
                       8'($urandom_range(0, 255)));
          normal_items++;
        end
        queue_plain(lsps_pkg::ACT_START);
        normal_items++;
        n_ticks = 24 * cnt * per + 6;
        repeat (n_ticks) begin
          if ($urandom_range(0, 7) == 0) begin
            queue_plain(3'($urandom_range(0, 7)));      // mostly bounced while busy
          end else begin
            queue_plain(lsps_pkg::ACT_TICK);
          end
          normal_items++;
        end
      end
      wait_drain();
      run_out_refresh();
    end

    wait_drain();
    repeat (8) @(posedge clk);
    if (fault_count == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end

endmodule
